// ===== src/rptd_pkg.sv =====
// ----------------------------------------------------------------------------
// rptd_pkg: shared types and constants of the RLE palette texel decoder
// Microcode word, sequencer status, register indexes, texel formats and the
// control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rptd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int FORMAT_W    = 2;
  localparam int PAL_COUNT_W = 9;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXEL_FORMAT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT   = 2'd2;

  // Texel formats; the unused code decodes as direct
  localparam logic [FORMAT_W-1:0] FMT_NIBBLE = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_BYTE   = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_DIRECT = 2'd2;

  localparam logic [PAL_COUNT_W-1:0] PAL_COUNT_RESET = 9'd256;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DECODE,
    OP_PAL_WRITE,
    OP_CLIP,
    OP_OUT,
    OP_LOAD_PAD,
    OP_FINISH
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_ENTRY_PAL,
    C_ENTRY_TEX,
    C_PAL_DONE,
    C_CLIP_SKIP,
    C_OUT_FREE,
    C_PAD
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_FETCH    = 4'd0;
  localparam step_t S_DECODE   = 4'd1;
  localparam step_t S_DISPATCH = 4'd2;
  localparam step_t S_PAL_WR   = 4'd3;
  localparam step_t S_TEX_CHK  = 4'd4;
  localparam step_t S_CLIP     = 4'd5;
  localparam step_t S_OUT      = 4'd6;
  localparam step_t S_EOB_CHK  = 4'd7;
  localparam step_t S_PAD_CLIP = 4'd8;
  localparam step_t S_PAD_OUT  = 4'd9;
  localparam step_t S_FINISH   = 4'd10;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic entry_pal;
    logic entry_tex;
    logic pal_done;
    logic clip_skip;
    logic pad_needed;
  } status_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      S_FETCH:    w = '{OP_ACCEPT,    C_IN_VALID,  S_DECODE,   S_FETCH};
      S_DECODE:   w = '{OP_DECODE,    C_ALWAYS,    S_DISPATCH, S_DISPATCH};
      S_DISPATCH: w = '{OP_NOP,       C_ENTRY_PAL, S_PAL_WR,   S_TEX_CHK};
      S_PAL_WR:   w = '{OP_PAL_WRITE, C_PAL_DONE,  S_EOB_CHK,  S_PAL_WR};
      S_TEX_CHK:  w = '{OP_NOP,       C_ENTRY_TEX, S_CLIP,     S_EOB_CHK};
      S_CLIP:     w = '{OP_CLIP,      C_CLIP_SKIP, S_EOB_CHK,  S_OUT};
      S_OUT:      w = '{OP_OUT,       C_OUT_FREE,  S_EOB_CHK,  S_OUT};
      S_EOB_CHK:  w = '{OP_LOAD_PAD,  C_PAD,       S_PAD_CLIP, S_FINISH};
      S_PAD_CLIP: w = '{OP_CLIP,      C_CLIP_SKIP, S_FINISH,   S_PAD_OUT};
      S_PAD_OUT:  w = '{OP_OUT,       C_OUT_FREE,  S_FINISH,   S_PAD_OUT};
      S_FINISH:   w = '{OP_FINISH,    C_ALWAYS,    S_FETCH,    S_FETCH};
      default:    w = '{OP_NOP,       C_ALWAYS,    S_FETCH,    S_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/rptd_if.sv =====
// ----------------------------------------------------------------------------
// rptd_if: stream channels of the RLE palette texel decoder
// Input channel carries body bytes, output channel carries texel runs.
// ----------------------------------------------------------------------------
`default_nettype none

interface rptd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] body_byte;
  logic       end_of_body;

  modport source (output valid, mode, body_byte, end_of_body, input ready);
  modport sink   (input valid, mode, body_byte, end_of_body, output ready);
endinterface

interface rptd_out_if #(
  parameter int COUNT_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [31:0]            texel_first;
  logic [31:0]            texel_second;
  logic                   second_valid;
  logic [COUNT_WIDTH-1:0] repeat_count;
  logic                   last_run;

  modport source (output valid, texel_first, texel_second, second_valid, repeat_count,
                  last_run, input ready);
  modport sink   (input valid, texel_first, texel_second, second_valid, repeat_count,
                  last_run, output ready);
endinterface

`default_nettype wire

// ===== src/rptd_seq.sv =====
// ----------------------------------------------------------------------------
// rptd_seq: microcode sequencer
// Step counter over the control store with two-way conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rptd_seq (
  input  logic              clk,
  input  logic              rst,
  input  rptd_pkg::status_t status,
  output rptd_pkg::op_t     op
);
  import rptd_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   taken;

  assign word = ucode_rom(step);
  assign op   = word.op;

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    taken = 1'b1;
      C_IN_VALID:  taken = status.in_valid;
      C_ENTRY_PAL: taken = status.entry_pal;
      C_ENTRY_TEX: taken = status.entry_tex;
      C_PAL_DONE:  taken = status.pal_done;
      C_CLIP_SKIP: taken = status.clip_skip;
      C_OUT_FREE:  taken = status.out_free;
      C_PAD:       taken = status.pad_needed;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? word.t_true : word.t_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rptd_pal_mem.sv =====
// ----------------------------------------------------------------------------
// rptd_pal_mem: palette store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rptd_pal_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== src/rptd_datapath.sv =====
// ----------------------------------------------------------------------------
// rptd_datapath: decoder datapath
// Run and entry state, palette fill, run clipping, lookups and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rptd_datapath #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rptd_pkg::op_t                        op,
  input  logic [rptd_pkg::FORMAT_W-1:0]        texel_format,
  input  logic [rptd_pkg::PAL_COUNT_W-1:0]     palette_count,
  input  logic [COUNT_WIDTH-1:0]               entry_count,
  input  logic                                 in_valid,
  input  logic                                 in_mode,
  input  logic [7:0]                           in_byte,
  input  logic                                 in_eob,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [31:0]                          texel_first,
  output logic [31:0]                          texel_second,
  output logic                                 second_valid,
  output logic [COUNT_WIDTH-1:0]               repeat_count,
  output logic                                 last_run,
  output rptd_pkg::status_t                    status
);
  import rptd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int PW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [PAL_COUNT_W-1:0] DEPTH_LIMIT = PAL_COUNT_W'(PALETTE_DEPTH);

  // item latched at transfer
  logic                   cur_mode;
  logic [7:0]             cur_byte;
  logic                   cur_eob;
  // body and run state
  logic                   body_open;
  logic                   body_mode;
  logic                   awaiting;
  logic [7:0]             run_remaining;
  logic                   run_dup;
  logic [31:0]            assembly;
  logic [1:0]             byte_idx;
  logic                   entry_done;
  logic [31:0]            entry;
  logic [COUNT_WIDTH-1:0] reps;
  logic [COUNT_WIDTH-1:0] emitted;
  logic [PW-1:0]          palette_written;
  // clipped run waiting for output
  logic [COUNT_WIDTH-1:0] run_n;
  logic                   run_last;
  logic                   hit_a;
  logic                   hit_b;
  logic [31:0]            rdata_a;
  logic [31:0]            rdata_b;

  logic                   width4;
  logic                   complete;
  logic [31:0]            asm_new;
  logic [7:0]             rem_dec;
  logic [PAL_COUNT_W-1:0] limit;
  logic                   pal_done;
  logic [COUNT_WIDTH-1:0] left;
  logic                   clip_skip;
  logic                   take_all;
  logic [COUNT_WIDTH-1:0] clip_n;
  logic [7:0]             idx_a;
  logic [7:0]             idx_b;
  logic                   new_body;
  logic                   out_free;
  logic                   mem_we;

  always_comb begin
    width4    = !cur_mode || texel_format[1];
    complete  = !width4 || (byte_idx == 2'd3);
    asm_new   = assembly | (32'(cur_byte) << {byte_idx, 3'b000});
    rem_dec   = run_remaining - 8'd1;
    limit     = (palette_count > DEPTH_LIMIT) ? DEPTH_LIMIT : palette_count;
    pal_done  = (reps == '0) || (PAL_COUNT_W'(palette_written) >= limit);
    left      = entry_count - emitted;
    clip_skip = emitted >= entry_count;
    take_all  = reps < left;
    clip_n    = take_all ? reps : left;
    idx_a     = (texel_format == FMT_NIBBLE) ? {4'b0000, entry[7:4]} : entry[7:0];
    idx_b     = {4'b0000, entry[3:0]};
    new_body  = !body_open || (in_mode != body_mode);
    out_free  = !out_valid || out_ready;
    mem_we    = (op == OP_PAL_WRITE) && !pal_done;
  end

  assign status = '{
    in_valid:   in_valid,
    out_free:   out_free,
    entry_pal:  entry_done && !cur_mode,
    entry_tex:  entry_done && cur_mode,
    pal_done:   pal_done,
    clip_skip:  clip_skip,
    pad_needed: cur_eob && cur_mode
  };

  rptd_pal_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_pal_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (palette_written[AW-1:0]),
    .wdata   (entry),
    .re      (op == OP_CLIP),
    .raddr_a (idx_a[AW-1:0]),
    .raddr_b (idx_b[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // control and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      body_open       <= 1'b0;
      body_mode       <= 1'b0;
      awaiting        <= 1'b1;
      run_remaining   <= '0;
      run_dup         <= 1'b0;
      assembly        <= '0;
      byte_idx        <= '0;
      entry_done      <= 1'b0;
      entry           <= '0;
      reps            <= '0;
      emitted         <= '0;
      palette_written <= '0;
      out_valid       <= 1'b0;
    end else begin
      // result register: loaded in the output step, emptied by a transfer
      if (op == OP_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_ACCEPT: begin
          if (in_valid && new_body) begin
            awaiting      <= 1'b1;
            run_remaining <= '0;
            run_dup       <= 1'b0;
            assembly      <= '0;
            byte_idx      <= '0;
            body_open     <= 1'b1;
            body_mode     <= in_mode;
            if (!in_mode) begin
              palette_written <= '0;
            end else begin
              emitted <= '0;
            end
          end
        end
        OP_DECODE: begin
          entry_done <= 1'b0;
          if (awaiting) begin
            run_dup       <= cur_byte[7];
            run_remaining <= {1'b0, cur_byte[6:0]} + 8'd1;
            awaiting      <= 1'b0;
            assembly      <= '0;
            byte_idx      <= '0;
          end else if (complete) begin
            entry         <= width4 ? asm_new : 32'(cur_byte);
            reps          <= run_dup ? COUNT_WIDTH'(run_remaining) : COUNT_WIDTH'(1);
            run_remaining <= run_dup ? 8'd0 : rem_dec;
            awaiting      <= run_dup || (rem_dec == 8'd0);
            assembly      <= '0;
            byte_idx      <= '0;
            entry_done    <= 1'b1;
          end else begin
            assembly <= asm_new;
            byte_idx <= byte_idx + 2'd1;
          end
        end
        OP_PAL_WRITE: begin
          if (!pal_done) begin
            palette_written <= palette_written + PW'(1);
            reps            <= reps - COUNT_WIDTH'(1);
          end
        end
        OP_CLIP: begin
          if (!clip_skip) begin
            emitted <= emitted + clip_n;
          end
        end
        OP_LOAD_PAD: begin
          entry <= '0;
          reps  <= '1;
        end
        OP_FINISH: begin
          if (cur_eob) begin
            awaiting      <= 1'b1;
            run_remaining <= '0;
            run_dup       <= 1'b0;
            assembly      <= '0;
            byte_idx      <= '0;
            body_open     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: latched item, clipped run, result register
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (in_valid) begin
          cur_mode <= in_mode;
          cur_byte <= in_byte;
          cur_eob  <= in_eob;
        end
      end
      OP_CLIP: begin
        run_n    <= clip_n;
        run_last <= !take_all;
        hit_a    <= {1'b0, idx_a} < PAL_COUNT_W'(palette_written);
        hit_b    <= {1'b0, idx_b} < PAL_COUNT_W'(palette_written);
      end
      OP_OUT: begin
        if (out_free) begin
          repeat_count <= run_n;
          last_run     <= run_last;
          case (texel_format)
            FMT_NIBBLE: begin
              texel_first  <= hit_a ? rdata_a : 32'h0;
              texel_second <= hit_b ? rdata_b : 32'h0;
              second_valid <= 1'b1;
            end
            FMT_BYTE: begin
              texel_first  <= hit_a ? rdata_a : 32'h0;
              texel_second <= 32'h0;
              second_valid <= 1'b0;
            end
            default: begin
              texel_first  <= entry;
              texel_second <= 32'h0;
              second_valid <= 1'b0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rle_palette_texel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rle_palette_texel_decoder_core: run-length texel decoder with palette
// Decodes descriptor-coded palette and texture bodies into texel runs.
// ----------------------------------------------------------------------------
// Run path: after the transfer of the byte that completes its entry, a run
//   passes decode, dispatch, texture check, clip and, unless clipped away, output;
//   output waits while the result register stays full.
// Flow: the sequencer walks one byte at a time; palette colors go one at a time
//   through the one write port; a texture end adds a padding run unless full.
// Reset: synchronous; the palette reads as zero past its fill count.
`default_nettype none

module rle_palette_texel_decoder_core #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rptd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_WIDTH-1:0]           cfg_data,
  // body bytes in, texel runs out
  rptd_in_if.sink                          in_item,
  rptd_out_if.source                       out_run
);
  import rptd_pkg::*;

  // Configuration registers. Writes land at once; the host must write only while
  // the decoder is idle: the block does not enforce this or guard mid-item changes.
  logic [FORMAT_W-1:0]    texel_format;
  logic [PAL_COUNT_W-1:0] palette_count;
  logic [COUNT_WIDTH-1:0] entry_count;

  // Sequencer/datapath control
  op_t     op;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format  <= FMT_BYTE;
      palette_count <= PAL_COUNT_RESET;
      entry_count   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXEL_FORMAT:  texel_format  <= cfg_data[FORMAT_W-1:0];
        CFG_PALETTE_COUNT: palette_count <= cfg_data[PAL_COUNT_W-1:0];
        CFG_ENTRY_COUNT:   entry_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input is only taken in the fetch step; one byte is in flight at a time.
  assign in_item.ready = (op == OP_ACCEPT);

  // Control store walk: fetch, decode, then either the palette fill loop or
  // clip/lookup/output of a texture run, then the optional padding run.
  rptd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // Datapath holds the run state, palette store and the result register that
  // separates the output transfer from the sequencer.
  rptd_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .texel_format  (texel_format),
    .palette_count (palette_count),
    .entry_count   (entry_count),
    .in_valid      (in_item.valid),
    .in_mode       (in_item.mode),
    .in_byte       (in_item.body_byte),
    .in_eob        (in_item.end_of_body),
    .out_ready     (out_run.ready),
    .out_valid     (out_run.valid),
    .texel_first   (out_run.texel_first),
    .texel_second  (out_run.texel_second),
    .second_valid  (out_run.second_valid),
    .repeat_count  (out_run.repeat_count),
    .last_run      (out_run.last_run),
    .status        (status)
  );

endmodule

`default_nettype wire

// ===== src/rptd_checker.sv =====
// ----------------------------------------------------------------------------
// rptd_checker: port-level checks of the RLE palette texel decoder
// Bound to the top level; watches only its channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rptd_checker #(
  parameter int COUNT_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [31:0]            texel_first,
  input logic [31:0]            texel_second,
  input logic                   second_valid,
  input logic [COUNT_WIDTH-1:0] repeat_count,
  input logic                   last_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(texel_first) &&
      $stable(texel_second) && $stable(second_valid) && $stable(repeat_count) &&
      $stable(last_run))
    else $error("result changed while stalled");

  // one byte at a time: no transfer in the cycle after a transfer
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a run needs at least clip, lookup and load after its byte
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too soon after a byte");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != '0)
    else $error("zero repeat count");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !second_valid |-> texel_second == 32'h0)
    else $error("second texel set outside pair format");

endmodule

bind rle_palette_texel_decoder_core rptd_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_rptd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .out_valid    (out_run.valid),
  .out_ready    (out_run.ready),
  .texel_first  (out_run.texel_first),
  .texel_second (out_run.texel_second),
  .second_valid (out_run.second_valid),
  .repeat_count (out_run.repeat_count),
  .last_run     (out_run.last_run)
);

`default_nettype wire

// ===== sim/tb_rle_palette_texel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_rle_palette_texel_decoder_core: self-checking bench of the RLE texel decoder
// Feeds palette and texture body bytes through the input channel and compares
// each texel run on the output channel with a behavioral prediction. The
// configuration changes between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle_palette_texel_decoder_core;
  import rptd_pkg::*;

  localparam int COUNT_W     = 24;
  localparam int PAL_DEPTH   = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet time before a register write: a palette duplicate run keeps the single
  // write port busy with one write per color after its transfer.
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_BYTES   = 100;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_TEXTURE = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] body_byte;
    logic       end_of_body;
  } body_item_t;

  typedef struct packed {
    logic [31:0]        texel_first;
    logic [31:0]        texel_second;
    logic               second_valid;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_run;
  } texel_run_t;

  // How a generated body ends
  typedef enum int {BODY_WHOLE, BODY_CUT, BODY_OPEN} body_shape_t;

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]     cfg_data;

  rptd_in_if                           in_ch ();
  rptd_out_if #(.COUNT_WIDTH(COUNT_W)) out_ch ();

  rle_palette_texel_decoder_core #(
    .PALETTE_DEPTH(PAL_DEPTH),
    .COUNT_WIDTH  (COUNT_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_ch),
    .out_run  (out_ch)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  body_item_t pending_bytes[$];   // bytes waiting for the driver
  texel_run_t expected_runs[$];   // predicted runs, oldest first
  body_item_t cur_byte;
  bit         in_busy = 1'b0;     // a byte is on the input channel
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatch_count = 0;
  int         runs_seen = 0;
  int         cycle_count = 0;

  // Predictor copy of the registers
  logic [FORMAT_W-1:0]    fmt_q;
  logic [PAL_COUNT_W-1:0] pal_cnt_q;
  logic [COUNT_W-1:0]     entry_cnt_q;

  // Predictor copy of the decoder state
  logic [31:0]            pal_mem [PAL_DEPTH];
  logic [PAL_COUNT_W-1:0] pal_fill;
  bit                     want_desc;
  bit                     run_dup;
  int unsigned            run_left;
  logic [31:0]            assembly;
  logic [1:0]             byte_idx;
  logic [COUNT_W-1:0]     runs_out;     // entries already covered by runs
  bit                     body_open;
  logic                   body_mode;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic reset_run_state();
    want_desc = 1'b1;
    run_left  = 0;
    run_dup   = 1'b0;
    assembly  = '0;
    byte_idx  = '0;
  endtask

  // A new body: palette bodies wipe the store, texture bodies restart the count
  task automatic open_body(input logic mode);
    reset_run_state();
    body_open = 1'b1;
    body_mode = mode;
    if (mode == MODE_PALETTE) begin
      foreach (pal_mem[i]) pal_mem[i] = '0;
      pal_fill = '0;
    end else begin
      runs_out = '0;
    end
  endtask

  // Colors past the kept count (saturated at the store depth) are dropped
  task automatic fill_palette(input logic [31:0] color, input int unsigned reps);
    int unsigned keep;
    keep = (pal_cnt_q > PAL_DEPTH) ? PAL_DEPTH : pal_cnt_q;
    for (int unsigned i = 0; i < reps && pal_fill < keep; i++) begin
      pal_mem[pal_fill[7:0]] = color;
      pal_fill = pal_fill + 1'b1;
    end
  endtask

  // One run, clipped at the entry count; nothing once the count is reached
  task automatic push_texel_run(input logic [31:0] entry, input int unsigned reps);
    texel_run_t r;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] n;
    if (runs_out < entry_cnt_q) begin
      left = entry_cnt_q - runs_out;
      n = (reps < 32'(left)) ? COUNT_W'(reps) : left;
      runs_out = runs_out + n;
      r = '0;
      case (fmt_q)
        FMT_NIBBLE: begin
          r.texel_first  = pal_mem[entry[7:4]];
          r.texel_second = pal_mem[entry[3:0]];
          r.second_valid = 1'b1;
        end
        FMT_BYTE: r.texel_first = pal_mem[entry[7:0]];
        default:  r.texel_first = entry;   // direct, and the unused code
      endcase
      r.repeat_count = n;
      r.last_run     = (runs_out == entry_cnt_q);
      expected_runs.push_back(r);
    end
  endtask

  task automatic decode_byte(input body_item_t it);
    int unsigned width;
    int unsigned reps;
    logic [31:0] entry;
    if (!body_open || it.mode != body_mode) open_body(it.mode);
    if (want_desc) begin
      run_dup   = it.body_byte[7];
      run_left  = it.body_byte[6:0] + 1;
      want_desc = 1'b0;
      assembly  = '0;
      byte_idx  = '0;
    end else begin
      // palette colors and direct texels are 4-byte little-endian words
      width = (it.mode == MODE_PALETTE || fmt_q >= FMT_DIRECT) ? 4 : 1;
      assembly = assembly | (32'(it.body_byte) << (8 * byte_idx));
      if (int'(byte_idx) + 1 >= width) begin
        entry = (width == 1) ? 32'(it.body_byte) : assembly;
        reps  = run_dup ? run_left : 1;
        if (it.mode == MODE_PALETTE) fill_palette(entry, reps);
        else push_texel_run(entry, reps);
        run_left = run_dup ? 0 : run_left - 1;
        if (run_left == 0) want_desc = 1'b1;
        assembly = '0;
        byte_idx = '0;
      end else begin
        byte_idx = byte_idx + 1'b1;
      end
    end
    if (it.end_of_body) begin
      // short texture body: one zero-entry run pads out the rest
      if (it.mode == MODE_TEXTURE) push_texel_run('0, COUNT_MAX);
      reset_run_state();
      body_open = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR: %s", what);
  endtask

  // Register writes go out at falling edges; the predictor copy follows at once
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_TEXEL_FORMAT:  fmt_q       = val[FORMAT_W-1:0];
      CFG_PALETTE_COUNT: pal_cnt_q   = val[PAL_COUNT_W-1:0];
      CFG_ENTRY_COUNT:   entry_cnt_q = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [FORMAT_W-1:0] fmt, input logic [PAL_COUNT_W-1:0] pcnt,
                           input logic [COUNT_W-1:0] ecnt);
    write_reg(CFG_TEXEL_FORMAT, COUNT_W'(fmt));
    write_reg(CFG_PALETTE_COUNT, COUNT_W'(pcnt));
    write_reg(CFG_ENTRY_COUNT, ecnt);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the input queue and the expected runs to empty, then let the
  // sequencer finish any palette writes that produce no run.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_busy || expected_runs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A well-formed run sequence with random content, then an end of some shape
  task automatic queue_body(input logic mode, input int n_runs, input body_shape_t shape);
    body_item_t seg[$];
    int unsigned width;
    int unsigned cnt;
    int unsigned cut;
    logic dup;
    width = (mode == MODE_PALETTE || fmt_q >= FMT_DIRECT) ? 4 : 1;
    for (int r = 0; r < n_runs; r++) begin
      dup = 1'($urandom_range(1));
      if (dup) cnt = ($urandom_range(7) == 0) ? 127 : $urandom_range(40);
      else if (width == 1 && $urandom_range(15) == 0) cnt = 127;
      else cnt = $urandom_range(width == 1 ? 6 : 2);
      seg.push_back('{mode, {dup, 7'(cnt)}, 1'b0});
      repeat ((dup ? 1 : cnt + 1) * width) seg.push_back('{mode, 8'($urandom), 1'b0});
    end
    case (shape)
      BODY_CUT: begin
        // end marker lands inside a run or inside an entry
        cut = $urandom_range(seg.size() - 1);
        while (seg.size() > cut + 1) void'(seg.pop_back());
        seg[seg.size() - 1].end_of_body = 1'b1;
      end
      BODY_OPEN: ;   // no end marker: the next body of another mode abandons it
      default: seg[seg.size() - 1].end_of_body = 1'b1;
    endcase
    foreach (seg[i]) pending_bytes.push_back(seg[i]);
  endtask

  // One phase: a palette first, then mostly texture bodies, some noise
  task automatic queue_phase(input int budget);
    int seg_start;
    int pick;
    seg_start = pending_bytes.size();
    queue_body(MODE_PALETTE, $urandom_range(2, 6), BODY_WHOLE);
    while (pending_bytes.size() - seg_start < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          pending_bytes.push_back('{1'($urandom_range(1)), 8'($urandom),
                                   ($urandom_range(3) == 0)});
      end else if (pick < 15) begin
        queue_body(MODE_PALETTE, $urandom_range(1, 4),
                   ($urandom_range(1) == 0) ? BODY_WHOLE : BODY_CUT);
      end else if (pick < 25) begin
        queue_body(MODE_TEXTURE, $urandom_range(1, 5), BODY_CUT);
      end else if (pick < 32) begin
        queue_body(MODE_TEXTURE, $urandom_range(1, 4), BODY_OPEN);
      end else begin
        queue_body(MODE_TEXTURE, $urandom_range(1, 6), BODY_WHOLE);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rle_palette_texel_decoder_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: one byte at a time from the pending queue, random gaps on the
  // input side and random stalls on the output side, all at falling edges.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_busy) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_byte = pending_bytes.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= cur_byte.mode;
          in_ch.body_byte   <= cur_byte.body_byte;
          in_ch.end_of_body <= cur_byte.end_of_body;
          in_busy = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: output transfers are checked against the oldest prediction;
  // input transfers feed the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    texel_run_t got;
    texel_run_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.texel_first, out_ch.texel_second, out_ch.second_valid,
                out_ch.repeat_count, out_ch.last_run};
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("run %0d arrived with nothing expected (%h)",
                                    runs_seen, got));
        end else begin
          want = expected_runs.pop_front();
          if (got.texel_first !== want.texel_first)
            report_mismatch($sformatf("run %0d texel_first %h, expected %h",
                                      runs_seen, got.texel_first, want.texel_first));
          if (got.texel_second !== want.texel_second)
            report_mismatch($sformatf("run %0d texel_second %h, expected %h",
                                      runs_seen, got.texel_second, want.texel_second));
          if (got.second_valid !== want.second_valid)
            report_mismatch($sformatf("run %0d second_valid %b, expected %b",
                                      runs_seen, got.second_valid, want.second_valid));
          if (got.repeat_count !== want.repeat_count)
            report_mismatch($sformatf("run %0d repeat_count %0d, expected %0d",
                                      runs_seen, got.repeat_count, want.repeat_count));
          if (got.last_run !== want.last_run)
            report_mismatch($sformatf("run %0d last_run %b, expected %b",
                                      runs_seen, got.last_run, want.last_run));
        end
        runs_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte('{in_ch.mode, in_ch.body_byte, in_ch.end_of_body});
        in_busy = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  // Directed palette: a duplicate pair of one color, then a literal pair of
  // all-ones and all-zeros. Leaves entries 0..3 filled.
  localparam logic [7:0] DIR_PALETTE [14] = '{
    8'h81, 8'h11, 8'h22, 8'h33, 8'h44,
    8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00
  };
  // Directed texture, two bodies with an entry count of 8:
  //   dup 3 of index 1, literal pair with index 255 (past the fill, reads
  //   zero) ending early, so padding covers the rest;
  //   dup 128 clipped to the count, then a literal run dropped entirely.
  localparam logic [7:0] DIR_TEXTURE [10] = '{
    8'h82, 8'h01, 8'h01, 8'h02, 8'hFF,
    8'hFF, 8'h03, 8'h7F, 8'h05, 8'h00
  };

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.body_byte   = '0;
    in_ch.end_of_body = 1'b0;
    out_ch.ready      = 1'b0;

    // register and decoder state after reset
    fmt_q       = FMT_BYTE;
    pal_cnt_q   = PAL_COUNT_RESET;
    entry_cnt_q = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;
    pal_fill  = '0;
    runs_out  = '0;
    body_open = 1'b0;
    body_mode = MODE_PALETTE;
    reset_run_state();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the first idle pattern
    send_idle_pct = 26;
    recv_idle_pct = 85;
    configure(FMT_BYTE, PAL_COUNT_RESET, 24'd8);
    foreach (DIR_PALETTE[i])
      pending_bytes.push_back('{MODE_PALETTE, DIR_PALETTE[i], (i == 13)});
    for (int i = 0; i < 9; i++)
      pending_bytes.push_back('{MODE_TEXTURE, DIR_TEXTURE[i], (i == 4 || i == 8)});
    drain();

    // Random part: three idle patterns, five register settings each
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_idle_pct = 26; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 5; ph++) begin
        configure(FORMAT_W'((regime * 5 + ph) % 4),
                  (ph == 0) ? PAL_COUNT_RESET :
                  (ph == 1) ? 9'd0 :
                  (ph == 2) ? 9'd511 :
                  (ph == 3) ? 9'd1 : 9'($urandom_range(2, 300)),
                  ((ph + regime) % 5 == 0) ? COUNT_MAX :
                  ((ph + regime) % 5 == 1) ? 24'd0 :
                  ((ph + regime) % 5 == 2) ? 24'd1 :
                  ((ph + regime) % 5 == 3) ? 24'($urandom) :
                                             24'($urandom_range(2, 100)));
        queue_phase(PHASE_BYTES);
        drain();
      end
    end

    if (expected_runs.size() != 0)
      report_mismatch($sformatf("%0d runs never arrived", expected_runs.size()));
    if (mismatch_count == 0) begin
      $display("rle_palette_texel_decoder_core verification clean");
    end else begin
      $display("rle_palette_texel_decoder_core verification failed");
    end
    $finish;
  end

endmodule
